[hdl/jbt_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jbt_pkg: shared types and constants of the JSON byte tokenizer
// Character codes, token kinds, field widths and the token record.
// ----------------------------------------------------------------------------
package jbt_pkg;

  // Field widths of the two channels.
  localparam int BYTE_W = 8;
  localparam int KIND_W = 4;
  localparam int POS_W  = 16;
  localparam int NUM_W  = 32;
  localparam int FRAC_W = 5;

  // Token kinds.
  localparam logic [KIND_W-1:0] KIND_LBRACE  = 4'd0;
  localparam logic [KIND_W-1:0] KIND_RBRACE  = 4'd1;
  localparam logic [KIND_W-1:0] KIND_LBRACK  = 4'd2;
  localparam logic [KIND_W-1:0] KIND_RBRACK  = 4'd3;
  localparam logic [KIND_W-1:0] KIND_COLON   = 4'd4;
  localparam logic [KIND_W-1:0] KIND_COMMA   = 4'd5;
  localparam logic [KIND_W-1:0] KIND_INTEGER = 4'd6;
  localparam logic [KIND_W-1:0] KIND_DECIMAL = 4'd7;
  localparam logic [KIND_W-1:0] KIND_STRING  = 4'd8;
  localparam logic [KIND_W-1:0] KIND_NULL    = 4'd9;
  localparam logic [KIND_W-1:0] KIND_UNKNOWN = 4'd10;

  // Character codes the lexer reacts to.
  localparam logic [BYTE_W-1:0] CH_LBRACE = 8'h7B;
  localparam logic [BYTE_W-1:0] CH_RBRACE = 8'h7D;
  localparam logic [BYTE_W-1:0] CH_LBRACK = 8'h5B;
  localparam logic [BYTE_W-1:0] CH_RBRACK = 8'h5D;
  localparam logic [BYTE_W-1:0] CH_COLON  = 8'h3A;
  localparam logic [BYTE_W-1:0] CH_COMMA  = 8'h2C;
  localparam logic [BYTE_W-1:0] CH_N      = 8'h6E;
  localparam logic [BYTE_W-1:0] CH_DOT    = 8'h2E;
  localparam logic [BYTE_W-1:0] CH_MINUS  = 8'h2D;
  localparam logic [BYTE_W-1:0] CH_QUOTE  = 8'h22;
  localparam logic [BYTE_W-1:0] CH_SPACE  = 8'h20;
  localparam logic [BYTE_W-1:0] CH_LF     = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_TAB    = 8'h09;
  localparam logic [BYTE_W-1:0] CH_ZERO   = 8'h30;
  localparam logic [BYTE_W-1:0] CH_NINE   = 8'h39;

  // Bytes skipped after the letter n, and the fraction count ceiling.
  localparam logic [1:0]        SKIP_LEN = 2'd3;
  localparam logic [FRAC_W-1:0] FRAC_MAX = 5'd31;

  // One result word.
  typedef struct packed {
    logic [KIND_W-1:0]        kind;
    logic [POS_W-1:0]         position;
    logic signed [NUM_W-1:0]  number_value;
    logic [FRAC_W-1:0]        fraction_digits;
    logic [POS_W-1:0]         content_start;
    logic [POS_W-1:0]         content_length;
    logic                     last_of_run;
  } jbt_token_t;

endpackage

[hdl/jbt_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jbt_if: channel interfaces of the JSON byte tokenizer
// Text byte channel and token channel, each with valid/ready handshake.
// ----------------------------------------------------------------------------
interface jbt_in_if;
  logic                       valid;
  logic                       ready;
  logic [jbt_pkg::BYTE_W-1:0] text_byte;
  logic                       final_byte;

  modport source (output valid, output text_byte, output final_byte, input ready);
  modport sink   (input valid, input text_byte, input final_byte, output ready);
endinterface

interface jbt_out_if;
  logic                             valid;
  logic                             ready;
  logic [jbt_pkg::KIND_W-1:0]       kind;
  logic [jbt_pkg::POS_W-1:0]        position;
  logic signed [jbt_pkg::NUM_W-1:0] number_value;
  logic [jbt_pkg::FRAC_W-1:0]       fraction_digits;
  logic [jbt_pkg::POS_W-1:0]        content_start;
  logic [jbt_pkg::POS_W-1:0]        content_length;
  logic                             last_of_run;

  modport source (output valid, output kind, output position, output number_value,
                  output fraction_digits, output content_start,
                  output content_length, output last_of_run, input ready);
  modport sink   (input valid, input kind, input position, input number_value,
                  input fraction_digits, input content_start,
                  input content_length, input last_of_run, output ready);
endinterface

[hdl/jbt_lexer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jbt_lexer: scanner state and token formation
// Holds the scan state and, for each accepted byte, forms up to two tokens.
// ----------------------------------------------------------------------------
module jbt_lexer #(
  parameter int OFFSET_WIDTH = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_fire,
  input  logic [jbt_pkg::BYTE_W-1:0] text_byte,
  input  logic                       final_byte,
  output jbt_pkg::jbt_token_t        tok0,
  output jbt_pkg::jbt_token_t        tok1,
  output logic [1:0]                 tok_count
);

  localparam int OW = OFFSET_WIDTH;

  // Scan modes.
  localparam logic [2:0] MODE_IDLE   = 3'd0;
  localparam logic [2:0] MODE_STRING = 3'd1;
  localparam logic [2:0] MODE_INT    = 3'd2;
  localparam logic [2:0] MODE_FRAC   = 3'd3;
  localparam logic [2:0] MODE_SKIP   = 3'd4;

  logic [2:0]                        mode_r,  mode_nxt;
  logic [1:0]                        skip_r,  skip_nxt;
  logic [OW-1:0]                     off_r,   off_nxt;
  logic [OW-1:0]                     sbeg_r,  sbeg_nxt;
  logic [jbt_pkg::NUM_W-1:0]         acc_r,   acc_nxt;
  logic                              neg_r,   neg_nxt;
  logic                              stop_r,  stop_nxt;
  logic [jbt_pkg::FRAC_W-1:0]        frac_r,  frac_nxt;
  logic                              first_r, first_nxt;

  logic                              is_digit, is_minus, is_dot;
  logic [jbt_pkg::NUM_W-1:0]         acc_x10;
  logic [OW-1:0]                     off_p1, off_p2;
  jbt_pkg::jbt_token_t               tok_a, tok_b, tok_c;
  logic                              a_v, b_v, c_v;
  logic                              do_idle;

  // Builds a token with the run marker cleared.
  function automatic jbt_pkg::jbt_token_t make_tok(
    input logic [jbt_pkg::KIND_W-1:0] kind,
    input logic [OW-1:0]              pos,
    input logic [jbt_pkg::NUM_W-1:0]  val,
    input logic [jbt_pkg::FRAC_W-1:0] frac,
    input logic [OW-1:0]              cs,
    input logic [OW-1:0]              cl
  );
    jbt_pkg::jbt_token_t t;
    t.kind            = kind;
    t.position        = jbt_pkg::POS_W'(pos);
    t.number_value    = val;
    t.fraction_digits = frac;
    t.content_start   = jbt_pkg::POS_W'(cs);
    t.content_length  = jbt_pkg::POS_W'(cl);
    t.last_of_run     = 1'b0;
    return t;
  endfunction

  // Number token from a given accumulator state.
  function automatic jbt_pkg::jbt_token_t num_tok(
    input logic [2:0]                 mode,
    input logic [OW-1:0]              pos,
    input logic [jbt_pkg::NUM_W-1:0]  acc,
    input logic                       neg,
    input logic [jbt_pkg::FRAC_W-1:0] frac
  );
    logic [jbt_pkg::NUM_W-1:0] v;
    v = neg ? (~acc + 1'b1) : acc;
    if (mode == MODE_INT) begin
      return make_tok(jbt_pkg::KIND_INTEGER, pos, v, '0, '0, '0);
    end
    return make_tok(jbt_pkg::KIND_DECIMAL, pos, v, frac, '0, '0);
  endfunction

  // Character classes and the times-ten accumulate step.
  assign is_digit = (text_byte >= jbt_pkg::CH_ZERO) && (text_byte <= jbt_pkg::CH_NINE);
  assign is_minus = (text_byte == jbt_pkg::CH_MINUS);
  assign is_dot   = (text_byte == jbt_pkg::CH_DOT);
  assign acc_x10  = (acc_r << 3) + (acc_r << 1) + {{(jbt_pkg::NUM_W-4){1'b0}}, text_byte[3:0]};
  assign off_p1   = off_r + OW'(1);
  assign off_p2   = off_r + OW'(2);

  // Next scan state and the tokens this byte produces.
  always_comb begin
    mode_nxt  = mode_r;
    skip_nxt  = skip_r;
    off_nxt   = off_r;
    sbeg_nxt  = sbeg_r;
    acc_nxt   = acc_r;
    neg_nxt   = neg_r;
    stop_nxt  = stop_r;
    frac_nxt  = frac_r;
    first_nxt = first_r;
    tok_a     = '0;
    tok_b     = '0;
    tok_c     = '0;
    a_v       = 1'b0;
    b_v       = 1'b0;
    c_v       = 1'b0;
    do_idle   = 1'b0;

    // First phase: extend or end the current construct.
    case (mode_r)
      MODE_INT, MODE_FRAC: begin
        first_nxt = 1'b0;
        if (is_digit) begin
          if (!stop_r) begin
            acc_nxt = acc_x10;
            if (mode_r == MODE_FRAC && frac_r != jbt_pkg::FRAC_MAX) begin
              frac_nxt = frac_r + 1'b1;
            end
          end
        end else if (is_minus) begin
          if (first_r) begin
            neg_nxt = 1'b1;
          end else begin
            stop_nxt = 1'b1;
          end
        end else if (is_dot && mode_r == MODE_INT) begin
          mode_nxt = MODE_FRAC;
        end else begin
          a_v      = 1'b1;
          tok_a    = num_tok(mode_r, off_r, acc_r, neg_r, frac_r);
          mode_nxt = MODE_IDLE;
          do_idle  = 1'b1;
        end
      end
      MODE_STRING: begin
        if (text_byte == jbt_pkg::CH_QUOTE) begin
          a_v      = 1'b1;
          tok_a    = make_tok(jbt_pkg::KIND_STRING, off_p1, '0, '0, sbeg_r, off_r - sbeg_r);
          mode_nxt = MODE_IDLE;
        end
      end
      MODE_SKIP: begin
        if (skip_r > 2'd1) begin
          skip_nxt = skip_r - 1'b1;
        end else begin
          skip_nxt = '0;
          mode_nxt = MODE_IDLE;
        end
      end
      default: begin
        mode_nxt = MODE_IDLE;
        do_idle  = 1'b1;
      end
    endcase

    // Second phase: lex the byte from the idle mode.
    if (do_idle) begin
      case (text_byte)
        jbt_pkg::CH_SPACE, jbt_pkg::CH_LF, jbt_pkg::CH_TAB: begin
        end
        jbt_pkg::CH_LBRACE: begin
          b_v   = 1'b1;
          tok_b = make_tok(jbt_pkg::KIND_LBRACE, off_r, '0, '0, '0, '0);
        end
        jbt_pkg::CH_RBRACE: begin
          b_v   = 1'b1;
          tok_b = make_tok(jbt_pkg::KIND_RBRACE, off_r, '0, '0, '0, '0);
        end
        jbt_pkg::CH_LBRACK: begin
          b_v   = 1'b1;
          tok_b = make_tok(jbt_pkg::KIND_LBRACK, off_r, '0, '0, '0, '0);
        end
        jbt_pkg::CH_RBRACK: begin
          b_v   = 1'b1;
          tok_b = make_tok(jbt_pkg::KIND_RBRACK, off_r, '0, '0, '0, '0);
        end
        jbt_pkg::CH_COLON: begin
          b_v   = 1'b1;
          tok_b = make_tok(jbt_pkg::KIND_COLON, off_r, '0, '0, '0, '0);
        end
        jbt_pkg::CH_COMMA: begin
          b_v   = 1'b1;
          tok_b = make_tok(jbt_pkg::KIND_COMMA, off_r, '0, '0, '0, '0);
        end
        jbt_pkg::CH_QUOTE: begin
          mode_nxt = MODE_STRING;
          sbeg_nxt = off_p1;
        end
        jbt_pkg::CH_N: begin
          b_v      = 1'b1;
          tok_b    = make_tok(jbt_pkg::KIND_NULL, off_r, '0, '0, '0, '0);
          mode_nxt = MODE_SKIP;
          skip_nxt = jbt_pkg::SKIP_LEN;
        end
        default: begin
          if (is_digit || is_minus) begin
            // A number starts; its first character is already folded in.
            mode_nxt  = MODE_INT;
            acc_nxt   = is_digit ? {{(jbt_pkg::NUM_W-4){1'b0}}, text_byte[3:0]} : '0;
            neg_nxt   = is_minus;
            stop_nxt  = 1'b0;
            frac_nxt  = '0;
            first_nxt = 1'b0;
          end else begin
            b_v   = 1'b1;
            tok_b = make_tok(jbt_pkg::KIND_UNKNOWN, off_r, '0, '0, '0, '0);
          end
        end
      endcase
    end

    // End of stream: flush an open number or string, then start over.
    if (final_byte) begin
      if (mode_nxt == MODE_INT || mode_nxt == MODE_FRAC) begin
        c_v   = 1'b1;
        tok_c = num_tok(mode_nxt, off_p1, acc_nxt, neg_nxt, frac_nxt);
      end else if (mode_nxt == MODE_STRING) begin
        c_v   = 1'b1;
        tok_c = make_tok(jbt_pkg::KIND_STRING, off_p2, '0, '0, sbeg_nxt, off_p1 - sbeg_nxt);
      end
      mode_nxt  = MODE_IDLE;
      skip_nxt  = '0;
      off_nxt   = '0;
      sbeg_nxt  = '0;
      acc_nxt   = '0;
      neg_nxt   = 1'b0;
      stop_nxt  = 1'b0;
      frac_nxt  = '0;
      first_nxt = 1'b0;
    end else begin
      off_nxt = off_p1;
    end
  end

  // Pack the tokens in order; at most two are ever present.
  always_comb begin
    tok0      = a_v ? tok_a : (b_v ? tok_b : tok_c);
    tok1      = b_v ? tok_b : tok_c;
    tok_count = 2'(a_v) + 2'(b_v) + 2'(c_v);
    tok0.last_of_run = (tok_count == 2'd1);
    tok1.last_of_run = 1'b1;
  end

  // Scan state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_IDLE;
      skip_r  <= '0;
      off_r   <= '0;
      sbeg_r  <= '0;
      acc_r   <= '0;
      neg_r   <= 1'b0;
      stop_r  <= 1'b0;
      frac_r  <= '0;
      first_r <= 1'b0;
    end else if (in_fire) begin
      mode_r  <= mode_nxt;
      skip_r  <= skip_nxt;
      off_r   <= off_nxt;
      sbeg_r  <= sbeg_nxt;
      acc_r   <= acc_nxt;
      neg_r   <= neg_nxt;
      stop_r  <= stop_nxt;
      frac_r  <= frac_nxt;
      first_r <= first_nxt;
    end
  end

endmodule

[hdl/jbt_out_fifo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jbt_out_fifo: result buffer of the tokenizer
// Four-word queue that takes up to two tokens per cycle and gives one.
// ----------------------------------------------------------------------------
module jbt_out_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  jbt_pkg::jbt_token_t tok0,
  input  jbt_pkg::jbt_token_t tok1,
  input  logic [1:0]          tok_count,
  input  logic                pop,
  output jbt_pkg::jbt_token_t head,
  output logic                not_empty,
  output logic                room
);

  jbt_pkg::jbt_token_t mem [4];
  logic [1:0]          wr_r, wr_nxt;
  logic [1:0]          rd_r, rd_nxt;
  logic [2:0]          cnt_r, cnt_nxt;
  logic [1:0]          n_in;

  assign n_in      = push ? tok_count : 2'd0;
  assign head      = mem[rd_r];
  assign not_empty = (cnt_r != 3'd0);
  // Room for a worst-case byte, which yields two words.
  assign room      = (cnt_r <= 3'd2);

  // Pointer and fill count update.
  always_comb begin
    wr_nxt  = wr_r + n_in;
    rd_nxt  = pop ? rd_r + 1'b1 : rd_r;
    cnt_nxt = cnt_r + 3'(n_in) - 3'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Word storage; no reset needed.
  always_ff @(posedge clk) begin
    if (n_in != 2'd0) begin
      mem[wr_r] <= tok0;
    end
    if (n_in == 2'd2) begin
      mem[wr_r + 2'd1] <= tok1;
    end
  end

endmodule

[hdl/json_byte_tokenizer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// json_byte_tokenizer: streaming JSON lexer, one byte per cycle while ready
// Channel   Dir  Word                         Meaning
// in_ch     in   text_byte, final_byte        next text byte, end-of-stream mark
// out_ch    out  kind, position, number_value, one token per word
//                fraction_digits, content_*,
//                last_of_run
// A byte is lexed in the cycle it is accepted and its tokens are in the
// result queue at the next edge, so a byte is taken each cycle that has room.
// Bytes that make two tokens fill the four-word queue faster than it drains;
// input ready drops while fewer than two words are free.
// Reset (synchronous, rst_n low) returns the scanner to offset zero, idle.
// A stalled output only blocks input once the queue holds three words.
// ----------------------------------------------------------------------------
module json_byte_tokenizer #(
  parameter int OFFSET_WIDTH = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  jbt_in_if.sink    in_ch,
  jbt_out_if.source out_ch
);

  logic                in_fire;
  logic                room;
  logic                not_empty;
  logic [1:0]          tok_count;
  jbt_pkg::jbt_token_t tok0, tok1, head;

  assign in_ch.ready = room;
  assign in_fire     = in_ch.valid && room;

  // Scanner.
  jbt_lexer #(
    .OFFSET_WIDTH(OFFSET_WIDTH)
  ) u_lexer (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_fire    (in_fire),
    .text_byte  (in_ch.text_byte),
    .final_byte (in_ch.final_byte),
    .tok0       (tok0),
    .tok1       (tok1),
    .tok_count  (tok_count)
  );

  // Result queue.
  jbt_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_fire),
    .tok0      (tok0),
    .tok1      (tok1),
    .tok_count (tok_count),
    .pop       (not_empty && out_ch.ready),
    .head      (head),
    .not_empty (not_empty),
    .room      (room)
  );

  // Output word.
  assign out_ch.valid           = not_empty;
  assign out_ch.kind            = head.kind;
  assign out_ch.position        = head.position;
  assign out_ch.number_value    = head.number_value;
  assign out_ch.fraction_digits = head.fraction_digits;
  assign out_ch.content_start   = head.content_start;
  assign out_ch.content_length  = head.content_length;
  assign out_ch.last_of_run     = head.last_of_run;

endmodule
